// File: sv/swpr_pkg.sv
// Shared types and constants for the sliding window packet receiver.
package swpr_pkg;

  localparam int MAX_SLOTS_DEF = 512;
  localparam logic [10:0] MAX_PAYLOAD = 11'd1461;
  localparam int CFG_DATA_W = 10;
  localparam int DIV_STEPS = 32;

  typedef enum logic [0:0] {
    REG_WINDOW   = 1'b0,
    REG_ACK_MODE = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    KIND_START = 3'd0,
    KIND_END   = 3'd1,
    KIND_DATA  = 3'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_STORED  = 3'd0,
    ST_DISCARD = 3'd1,
    ST_DUP     = 3'd2,
    ST_STARTED = 3'd3,
    ST_ENDED   = 3'd4,
    ST_FATAL   = 3'd5
  } status_t;

  typedef struct packed {
    logic [2:0]  packet_kind;
    logic [31:0] seq_number;
    logic [15:0] header_length;
    logic [10:0] received_length;
    logic        checksum_good;
  } packet_t;

  typedef struct packed {
    logic        ack_valid;
    logic [31:0] ack_number;
    logic [2:0]  status;
    logic [9:0]  released_packets;
    logic [19:0] released_bytes;
    logic [31:0] next_expected;
  } result_t;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic decide;
    logic mod_start;
    logic mod_take;
    logic rd_idx;
    logic wr_idx;
    logic rd_h;
    logic rel_step;
    logic finish_rel;
  } swpr_cmd_t;

  typedef struct packed {
    logic win_go;
    logic mod_done;
    logic present;
    logic clear_last;
  } swpr_stat_t;

endpackage

// File: sv/swpr_rem.sv
// Iterative remainder unit: one dividend bit per cycle.
module swpr_rem import swpr_pkg::*; #(
  parameter int WW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [WW-1:0] divisor,
  output logic          done,
  output logic [WW-1:0] rem
);

  logic [31:0] quot;
  logic [4:0]  cnt;
  logic        running;
  logic [WW:0] trial;

  assign trial = {rem, quot[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(DIV_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (running) begin
      quot <= {quot[30:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= WW'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[WW-1:0];
      end
    end
  end

endmodule

// File: sv/swpr_ctrl.sv
// Sequencer for header decode, slot store and in-order release.
module swpr_ctrl import swpr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  swpr_stat_t stat,
  output swpr_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DECIDE = 8'b0000_0100,
    S_MODW   = 8'b0000_1000,
    S_RDIDX  = 8'b0001_0000,
    S_WRIDX  = 8'b0010_0000,
    S_RDH    = 8'b0100_0000,
    S_CHK    = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (stat.win_go) begin
          cmd.mod_start = 1'b1;
          state_next = S_MODW;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MODW: begin
        if (stat.mod_done) begin
          cmd.mod_take = 1'b1;
          state_next = S_RDIDX;
        end
      end
      S_RDIDX: begin
        cmd.rd_idx = 1'b1;
        state_next = S_WRIDX;
      end
      S_WRIDX: begin
        cmd.wr_idx = 1'b1;
        state_next = S_RDH;
      end
      S_RDH: begin
        cmd.rd_h = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (stat.present) begin
          cmd.rel_step = 1'b1;
          state_next = S_RDH;
        end else begin
          cmd.finish_rel = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

// File: sv/swpr_dp.sv
// Datapath: session state, slot memory, release accumulators, result register.
module swpr_dp import swpr_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  swpr_cmd_t             cmd,
  output swpr_stat_t            stat,
  input  packet_t               packet,
  input  logic                  cfg_we,
  input  reg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output result_t               result,
  output logic                  done
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int WW = $clog2(MAX_SLOTS + 1);

  logic [9:0]  win_cfg;
  logic        ack_mode;
  logic        session_open, session_over;
  logic [31:0] expected_seq;

  logic [2:0]  lat_kind;
  logic [31:0] lat_seq;
  logic [15:0] lat_hlen;
  logic [10:0] lat_rlen;
  logic        lat_good;

  logic [WW-1:0]    w;
  logic [12:0]      ws13;
  logic [WW-1:0]    h, idx, rem;
  logic [WW:0]      idx_sum;
  logic [WW-1:0]    diff;
  logic [IDX_W-1:0] clr_idx;
  logic [9:0]       rel_pk;
  logic [19:0]      rel_by;
  status_t          slot_st;
  logic             mod_done;

  logic [11:0]      slot_mem [MAX_SLOTS];
  logic [11:0]      rdata;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [11:0]      mem_wdata;

  // decision of the fast path
  status_t     dec_status;
  logic        dec_ackv, dec_open, dec_over, win_go;
  logic [31:0] dec_ackn, dec_exp;
  logic [32:0] limit;

  assign ws13 = {3'b0, win_cfg};
  always_comb begin
    if (win_cfg == '0) w = WW'(1);
    else if (ws13 > 13'(MAX_SLOTS)) w = WW'(MAX_SLOTS);
    else w = WW'(win_cfg);
  end

  assign limit = {1'b0, expected_seq} + 33'(w);

  always_comb begin
    dec_status = ST_DISCARD;
    dec_ackv   = 1'b0;
    dec_ackn   = '0;
    dec_open   = session_open;
    dec_over   = session_over;
    dec_exp    = expected_seq;
    win_go     = 1'b0;
    if (session_over || lat_hlen != {5'b0, lat_rlen}) begin
      dec_status = ST_DISCARD;
    end else if (!lat_good) begin
      if (lat_kind == KIND_START) begin
        dec_status = ST_FATAL;
        dec_open   = 1'b0;
        dec_over   = 1'b1;
      end
    end else if (lat_kind == KIND_START) begin
      if (session_open) begin
        dec_status = ST_DUP;
      end else begin
        dec_open   = 1'b1;
        dec_exp    = '0;
        dec_status = ST_STARTED;
        dec_ackv   = 1'b1;
        dec_ackn   = lat_seq;
      end
    end else if (lat_kind == KIND_END) begin
      if (session_open) begin
        dec_status = ST_ENDED;
        dec_ackv   = 1'b1;
        dec_ackn   = lat_seq;
        dec_open   = 1'b0;
        dec_over   = 1'b1;
      end
    end else if (lat_kind == KIND_DATA && session_open) begin
      if ({1'b0, lat_seq} >= limit) begin
        dec_status = ST_DISCARD;
      end else if (lat_seq < expected_seq) begin
        dec_status = ST_DUP;
        dec_ackv   = 1'b1;
        dec_ackn   = ack_mode ? lat_seq : expected_seq;
      end else begin
        win_go = 1'b1;
      end
    end
  end

  swpr_rem #(.WW(WW)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (expected_seq),
    .divisor  (w),
    .done     (mod_done),
    .rem      (rem)
  );

  // offset inside the window is below w, so one subtract wraps it
  assign diff    = WW'(lat_seq - expected_seq);
  assign idx_sum = {1'b0, rem} + {1'b0, diff};

  assign stat.win_go     = win_go;
  assign stat.mod_done   = mod_done;
  assign stat.present    = rdata[11];
  assign stat.clear_last = (clr_idx == IDX_W'(MAX_SLOTS - 1));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = h[IDX_W-1:0];
    mem_wdata = {1'b0, rdata[10:0]};
    if (cmd.clear_wr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx;
      mem_wdata = '0;
    end else if (cmd.wr_idx && !rdata[11]) begin
      mem_we    = 1'b1;
      mem_waddr = idx[IDX_W-1:0];
      mem_wdata = {1'b1, lat_rlen};
    end else if (cmd.rel_step) begin
      mem_we = 1'b1;
    end
  end

  assign mem_raddr = cmd.rd_idx ? idx[IDX_W-1:0] : h[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_idx || cmd.rd_h) rdata <= slot_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_cfg      <= 10'd512;
      ack_mode     <= 1'b0;
      session_open <= 1'b0;
      session_over <= 1'b0;
      expected_seq <= '0;
      clr_idx      <= '0;
      done         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW:   win_cfg  <= cfg_data;
          REG_ACK_MODE: ack_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.clear_wr) clr_idx <= clr_idx + IDX_W'(1);
      if (cmd.decide) begin
        session_open <= dec_open;
        session_over <= dec_over;
        expected_seq <= dec_exp;
      end
      if (cmd.rel_step) expected_seq <= expected_seq + 32'd1;
      done <= (cmd.decide && !win_go) || cmd.finish_rel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lat_kind <= packet.packet_kind;
      lat_seq  <= packet.seq_number;
      lat_hlen <= packet.header_length;
      lat_good <= packet.checksum_good;
      lat_rlen <= (packet.received_length > MAX_PAYLOAD) ? MAX_PAYLOAD
                                                          : packet.received_length;
    end
    if (cmd.decide) begin
      rel_pk <= '0;
      rel_by <= '0;
    end
    if (cmd.mod_take) begin
      h   <= rem;
      idx <= (idx_sum >= {1'b0, w}) ? WW'(idx_sum - {1'b0, w}) : idx_sum[WW-1:0];
    end
    if (cmd.wr_idx) slot_st <= rdata[11] ? ST_DUP : ST_STORED;
    if (cmd.rel_step) begin
      rel_pk <= rel_pk + 10'd1;
      rel_by <= rel_by + {9'b0, rdata[10:0]};
      h      <= (h + WW'(1) == w) ? '0 : h + WW'(1);
    end
    if (cmd.decide && !win_go) begin
      result.ack_valid        <= dec_ackv;
      result.ack_number       <= dec_ackn;
      result.status           <= dec_status;
      result.released_packets <= '0;
      result.released_bytes   <= '0;
      result.next_expected    <= dec_exp;
    end else if (cmd.finish_rel) begin
      result.ack_valid        <= 1'b1;
      result.ack_number       <= ack_mode ? lat_seq : expected_seq;
      result.status           <= slot_st;
      result.released_packets <= rel_pk;
      result.released_bytes   <= rel_by;
      result.next_expected    <= expected_seq;
    end
  end

endmodule

// File: sv/sliding_window_packet_receiver.sv
// Top level of the sliding window packet receiver.
// One packet header is taken when start is high and busy is low; its single result
// appears on result for one cycle with done high and must be taken then. Control,
// start, end, stale and out-of-window headers are decided without the remainder unit.
// A data header inside the window waits on the bit-serial remainder unit that finds
// the slot of the expected number, then takes a read and a write of the target slot,
// then one read and one check of the slot memory per slot visited. After reset the
// slot memory is cleared with busy high; configuration writes are taken at any time.
module sliding_window_packet_receiver import swpr_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  packet_t               packet,
  output logic                  done,
  output result_t               result,
  input  logic                  cfg_we,
  input  reg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  swpr_cmd_t  cmd;
  swpr_stat_t stat;

  swpr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  swpr_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .packet    (packet),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result),
    .done      (done)
  );

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without an item in work");

  a_stored_acks: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_STORED) |-> result.ack_valid)
    else $error("stored item without ack");

  a_release_kind: assert property (@(posedge clk) disable iff (rst)
    (done && result.released_packets != '0) |->
      (result.status == ST_STORED || result.status == ST_DUP))
    else $error("release on a non-data result");

  a_noack_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.ack_valid) |-> (result.ack_number == '0))
    else $error("ack number without ack");

endmodule

// File: tb/sv/sliding_window_packet_receiver_tb.sv
// Testbench for the sliding window packet receiver: directed and random headers, self-checked.
module sliding_window_packet_receiver_tb;
  import swpr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] KIND_ACK   = 3'd3;
  localparam logic [2:0] KIND_OTHER = 3'd4;
  localparam int SLOTS = 512;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  packet_t packet;
  logic done;
  result_t result;
  logic cfg_we;
  reg_index_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sliding_window_packet_receiver u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .packet(packet),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow receiver state
  logic [9:0]  win_reg;
  logic        sel_ack;
  logic        in_session;
  logic        closed;
  logic [31:0] exp_seq;
  logic        present_q [SLOTS];
  logic [10:0] length_q [SLOTS];

  result_t pending_results[$];
  int unsigned mismatches;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [9:0] active_window();
    if (win_reg == 10'd0) return 10'd1;
    if (win_reg > SLOTS) return 10'(SLOTS);
    return win_reg;
  endfunction

  function automatic logic [10:0] clip_len(logic [10:0] l);
    return (l > MAX_PAYLOAD) ? MAX_PAYLOAD : l;
  endfunction

  task automatic apply_header(input packet_t p, output result_t r);
    logic [10:0] rl;
    logic [32:0] lim;
    logic [9:0]  w;
    logic [9:0]  slot;
    logic [9:0]  h;
    rl = clip_len(p.received_length);
    w  = active_window();
    r  = '0;
    r.status = ST_DISCARD;
    if (closed || p.header_length != {5'd0, rl}) begin
      r.status = ST_DISCARD;
    end else if (!p.checksum_good) begin
      if (p.packet_kind == KIND_START) begin
        r.status = ST_FATAL;
        in_session = 1'b0;
        closed = 1'b1;
      end
    end else if (p.packet_kind == KIND_START) begin
      if (in_session) begin
        r.status = ST_DUP;
      end else begin
        in_session = 1'b1;
        exp_seq = '0;
        r.status = ST_STARTED;
        r.ack_valid = 1'b1;
        r.ack_number = p.seq_number;
      end
    end else if (p.packet_kind == KIND_END) begin
      if (in_session) begin
        r.status = ST_ENDED;
        r.ack_valid = 1'b1;
        r.ack_number = p.seq_number;
        in_session = 1'b0;
        closed = 1'b1;
      end
    end else if (p.packet_kind == KIND_DATA && in_session) begin
      lim = {1'b0, exp_seq} + {23'd0, w};
      if ({1'b0, p.seq_number} >= lim) begin
        r.status = ST_DISCARD;
      end else if (p.seq_number < exp_seq) begin
        r.status = ST_DUP;
        r.ack_valid = 1'b1;
        r.ack_number = sel_ack ? p.seq_number : exp_seq;
      end else begin
        slot = 10'(p.seq_number % w);
        if (!present_q[slot]) begin
          present_q[slot] = 1'b1;
          length_q[slot] = rl;
          r.status = ST_STORED;
        end else begin
          r.status = ST_DUP;
        end
        for (int n = 0; n < w; n++) begin
          h = 10'(exp_seq % w);
          if (!present_q[h]) break;
          r.released_bytes = r.released_bytes + 20'(length_q[h]);
          present_q[h] = 1'b0;
          exp_seq = exp_seq + 32'd1;
          r.released_packets = r.released_packets + 10'd1;
        end
        r.ack_valid = 1'b1;
        r.ack_number = sel_ack ? p.seq_number : exp_seq;
      end
    end
    r.next_expected = exp_seq;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(input packet_t p);
    result_t r;
    start = 1'b1;
    packet = p;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_header(p, r);
    pending_results.push_back(r);
    @(negedge clk);
    start = 1'b0;
    repeat (pick_gap()) @(negedge clk);
  endtask

  function automatic packet_t hdr(logic [2:0] k, logic [31:0] s, logic [10:0] rl,
                                  logic good);
    packet_t p;
    p.packet_kind = k;
    p.seq_number = s;
    p.received_length = rl;
    p.header_length = {5'd0, clip_len(rl)};
    p.checksum_good = good;
    return p;
  endfunction

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [9:0] val);
    drain();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    if (idx == REG_WINDOW) win_reg = val;
    else sel_ack = val[0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  always @(posedge clk) begin
    result_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result);
      end else begin
        e = pending_results.pop_front();
        if (result.ack_valid !== e.ack_valid || result.ack_number !== e.ack_number ||
            result.status !== e.status ||
            result.released_packets !== e.released_packets ||
            result.released_bytes !== e.released_bytes ||
            result.next_expected !== e.next_expected) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", e, result);
        end
      end
    end
  end

  // before START nothing is accepted into the window
  task automatic test_before_session();
    send_item(hdr(KIND_DATA, 32'd0, 11'd100, 1'b1));
    send_item(hdr(KIND_END, 32'd5, 11'd0, 1'b1));
    send_item(hdr(KIND_ACK, 32'hFFFF_FFFF, 11'd0, 1'b1));
    send_item(hdr(KIND_OTHER, 32'd7, 11'd3, 1'b1));
    send_item(hdr(3'd7, 32'd7, 11'd3, 1'b1));
  endtask

  task automatic test_session_open();
    packet_t p;
    p = hdr(KIND_START, 32'd9, 11'd0, 1'b1);
    p.header_length = 16'hFFFF;               // length mismatch discards START too
    send_item(p);
    send_item(hdr(KIND_START, 32'hA5A5_5A5A, 11'd0, 1'b1));
    send_item(hdr(KIND_START, 32'd1, 11'd0, 1'b1));   // duplicate start
  endtask

  task automatic test_window_edges();
    packet_t p;
    write_reg(REG_WINDOW, 10'd4);
    send_item(hdr(KIND_DATA, 32'd2, 11'd2047, 1'b1)); // clipped length
    send_item(hdr(KIND_DATA, 32'd1, 11'd1461, 1'b1));
    send_item(hdr(KIND_DATA, 32'd1, 11'd5, 1'b1));    // slot full
    send_item(hdr(KIND_DATA, 32'd4, 11'd0, 1'b1));    // beyond window
    send_item(hdr(KIND_DATA, 32'd0, 11'd1024, 1'b1)); // releases three
    send_item(hdr(KIND_DATA, 32'd0, 11'd1, 1'b1));    // stale
    send_item(hdr(KIND_DATA, 32'd3, 11'd8, 1'b0));    // bad checksum
    p = hdr(KIND_DATA, 32'd3, 11'd8, 1'b1);
    p.header_length = 16'h8000;
    send_item(p);
    write_reg(REG_WINDOW, 10'd0);
    send_item(hdr(KIND_DATA, 32'd4, 11'd10, 1'b1));
    send_item(hdr(KIND_DATA, 32'd6, 11'd10, 1'b1));
    write_reg(REG_WINDOW, 10'h3FF);
    send_item(hdr(KIND_DATA, 32'hFFFF_FFFF, 11'd7, 1'b1));
    send_item(hdr(KIND_DATA, exp_seq + 511, 11'd7, 1'b1));
  endtask

  task automatic test_ack_modes();
    write_reg(REG_ACK_MODE, 10'd1);
    send_item(hdr(KIND_DATA, exp_seq + 3, 11'd40, 1'b1));
    send_item(hdr(KIND_DATA, 32'd1, 11'd40, 1'b1));
    write_reg(REG_ACK_MODE, 10'd0);
    send_item(hdr(KIND_DATA, exp_seq, 11'd40, 1'b1));
  endtask

  task automatic random_item();
    int unsigned r;
    logic [9:0] w;
    logic [10:0] rl;
    packet_t p;
    w = active_window();
    rl = 11'($urandom_range(0, 2047));
    r = $urandom_range(0, 99);
    if (r < 75) begin
      p = hdr(KIND_DATA, exp_seq + $urandom_range(0, w - 1), rl, 1'b1);
    end else if (r < 81) begin
      p = hdr(KIND_DATA, exp_seq - $urandom_range(1, 600), rl, 1'b1);
    end else if (r < 86) begin
      p = hdr(KIND_DATA, exp_seq + w + $urandom_range(0, 50), rl, 1'b1);
    end else if (r < 90) begin
      p = hdr(KIND_DATA, $urandom, rl, 1'b1);
    end else begin
      p.packet_kind = 3'($urandom_range(0, 7));
      p.seq_number = $urandom;
      p.received_length = rl;
      p.header_length = ($urandom_range(0, 1) != 0) ? 16'($urandom) : {5'd0, clip_len(rl)};
      p.checksum_good = 1'($urandom_range(0, 1));
      // keep the session alive: no accepted END, no fatal START
      if ((p.packet_kind == KIND_START && !p.checksum_good) ||
          (p.packet_kind == KIND_END && p.checksum_good))
        p.header_length = {5'd0, clip_len(rl)} + 16'd1;
    end
    send_item(p);
  endtask

  task automatic test_random_traffic();
    logic [9:0] windows [7] = '{10'd1, 10'd512, 10'd3, 10'd1023, 10'd64, 10'd17, 10'd0};
    foreach (windows[i]) begin
      write_reg(REG_WINDOW, windows[i]);
      write_reg(REG_ACK_MODE, 10'($urandom_range(0, 1)));
      repeat (150) random_item();
    end
  endtask

  task automatic test_close();
    send_item(hdr(KIND_END, 32'hFFFF_FFFE, 11'd0, 1'b1));
    send_item(hdr(KIND_START, 32'd0, 11'd0, 1'b1));
    send_item(hdr(KIND_START, 32'd0, 11'd0, 1'b0));
    send_item(hdr(KIND_DATA, exp_seq, 11'd10, 1'b1));
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    packet = '0;
    cfg_we = 1'b0;
    cfg_index = REG_WINDOW;
    cfg_data = '0;
    mismatches = 0;
    win_reg = 10'd512;
    sel_ack = 1'b0;
    in_session = 1'b0;
    closed = 1'b0;
    exp_seq = '0;
    foreach (present_q[i]) begin
      present_q[i] = 1'b0;
      length_q[i] = '0;
    end
    repeat (12) @(negedge clk);
    rst = 1'b0;
    test_before_session();
    test_session_open();
    test_window_edges();
    test_ack_modes();
    test_random_traffic();
    test_close();
    drain();
    repeat (50) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// File: sliding_window_packet_receiver.f
sv/swpr_pkg.sv
sv/swpr_rem.sv
sv/swpr_ctrl.sv
sv/swpr_dp.sv
sv/sliding_window_packet_receiver.sv
tb/sv/sliding_window_packet_receiver_tb.sv
